>>> hw/rtl/bcdsr_pkg.sv
// Shared types and constants for the BCD shift-register display driver.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcdsr_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int MAX_FRAMES  = 4;
    localparam int FRAME_COUNT = (DIGIT_COUNT < 1) ? 1 :
                                 ((DIGIT_COUNT > MAX_FRAMES) ? MAX_FRAMES : DIGIT_COUNT);

    localparam int VALUE_W   = 16;
    localparam int NIBBLE_W  = 4;
    localparam int BCD_W     = NIBBLE_W * MAX_FRAMES;
    localparam int POS_W     = 2;
    localparam int BIT_W     = 3;
    localparam int STEP_W    = 4;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [POS_W-1:0]  LAST_DIGIT = POS_W'(FRAME_COUNT - 1);
    localparam logic [BIT_W-1:0]  LAST_BIT   = 3'd7;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL  = QCNT_W'(QDEPTH);

    typedef logic [BCD_W-1:0] bcd_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic bcd_word_t bcd_adjust(input bcd_word_t w);
        bcd_word_t r;
        r = w;
        for (int d = 0; d < MAX_FRAMES; d++)
        begin
            if (w[d*NIBBLE_W +: NIBBLE_W] >= 4'd5)
            begin
                r[d*NIBBLE_W +: NIBBLE_W] = w[d*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcdsr_front.sv
// Front end: accepts a request and converts the binary value to four BCD digits.
// One shift-and-adjust step per cycle; depends on bcdsr_pkg.
`default_nettype none

module bcdsr_front
    import bcdsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    input  wire q_status_t          q_status,
    output logic                    push,
    output bcd_word_t               push_data
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    bcd_word_t          bcd_reg, bcd_next;
    bcd_word_t          adj;

    assign in_stall  = busy_reg | done_reg;
    assign push      = done_reg & ~q_status.full;
    assign push_data = bcd_reg;
    assign adj       = bcd_adjust(bcd_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (in_valid && !in_stall)
        begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = value;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (push)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/bcdsr_queue.sv
// Two-entry queue of converted BCD words between front and back end.
// Depends on bcdsr_pkg.
`default_nettype none

module bcdsr_queue
    import bcdsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire bcd_word_t push_data,
    input  wire logic      pop,
    output bcd_word_t      head,
    output q_status_t      q_status
);

    bcd_word_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head           = mem[rptr_reg];
    assign q_status.full  = (count_reg == QCNT_FULL);
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bcdsr_back.sv
// Back end: serializes one BCD word as 8-bit frames, ones digit first.
// Output fields are decoded combinationally from registers; depends on bcdsr_pkg.
`default_nettype none

module bcdsr_back
    import bcdsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire q_status_t   q_status,
    input  wire bcd_word_t   head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             serial_bit,
    output logic [POS_W-1:0] digit_position,
    output logic [BIT_W-1:0] bit_index,
    output logic             latch_after,
    output logic             last
);

    logic             active_reg, active_next;
    bcd_word_t        word_reg, word_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [NIBBLE_W-1:0] digit;
    logic             advance;

    assign digit          = word_reg[pos_reg*NIBBLE_W +: NIBBLE_W];
    assign out_valid      = active_reg;
    assign digit_position = pos_reg;
    assign bit_index      = bit_reg;
    assign latch_after    = (bit_reg == LAST_BIT);
    assign last           = latch_after && (pos_reg == LAST_DIGIT);
    assign serial_bit     = bit_reg[2] ? (bit_reg[1:0] == pos_reg)
                                       : digit[2'd3 - bit_reg[1:0]];
    assign advance        = active_reg & ~out_stall;
    assign pop            = ~q_status.empty & (~active_reg | (advance & last));

    always_comb
    begin
        active_next = active_reg;
        word_next   = word_reg;
        pos_next    = pos_reg;
        bit_next    = bit_reg;
        priority if (pop)
        begin
            active_next = 1'b1;
            word_next   = head;
            pos_next    = '0;
            bit_next    = '0;
        end
        else if (advance)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else if (latch_after)
            begin
                pos_next = pos_reg + 1'b1;
                bit_next = '0;
            end
            else
            begin
                bit_next = bit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/bcd_shift_register_display_driver.sv
// Top level of the BCD shift-register display driver.
// Instantiates bcdsr_front, bcdsr_queue and bcdsr_back; depends on bcdsr_pkg.
//
// Each request carries a 16-bit value and yields 32 result beats: four 8-bit
// frames (ones, tens, hundreds, thousands), one frame bit per beat, BCD digit
// MSB first in bits 0-3 and a one-hot digit select in bits 4-7. The serializer
// moves one bit per cycle unless out_stall holds it, and it sets the sustained
// rate. The binary-to-BCD conversion overlaps the serialization of the previous
// request through a two-entry queue, so back-to-back requests stream with no gap
// on the output. The first result appears once the converted word has been
// pushed into the queue and loaded into the serializer registers.
`default_nettype none

module bcd_shift_register_display_driver
    import bcdsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    serial_bit,
    output logic [POS_W-1:0]        digit_position,
    output logic [BIT_W-1:0]        bit_index,
    output logic                    latch_after,
    output logic                    last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    bcd_word_t push_data;
    bcd_word_t head;

    bcdsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    bcdsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    bcdsr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .serial_bit     (serial_bit),
        .digit_position (digit_position),
        .bit_index      (bit_index),
        .latch_after    (latch_after),
        .last           (last)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bcdsr_checker.sv
// Port-level checks for the BCD shift-register display driver.
// Bound to bcd_shift_register_display_driver; depends on bcdsr_pkg.
`default_nettype none

module bcdsr_checker
    import bcdsr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               serial_bit,
    input wire logic [POS_W-1:0]   digit_position,
    input wire logic [BIT_W-1:0]   bit_index,
    input wire logic               latch_after,
    input wire logic               last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(serial_bit)
            && $stable(digit_position) && $stable(bit_index))
        else $error("stalled result changed");

    a_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (latch_after == (bit_index == LAST_BIT)))
        else $error("latch mark not on eighth bit");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> latch_after && (digit_position == LAST_DIGIT))
        else $error("last mark outside final frame bit");

    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a request's frames");

    a_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_index[2] |-> (serial_bit == (bit_index[1:0] == digit_position)))
        else $error("digit select bit wrong");

endmodule

bind bcd_shift_register_display_driver bcdsr_checker u_bcdsr_checker (.*);

`default_nettype wire
